/* rtl/core/scr_pkg.sv */
package scr_pkg;

    localparam int XW = 32;  // coordinate width
    localparam int RW = 31;  // radius width
    localparam int WW = 80;  // wide working width for rounding and clamping

    localparam logic signed [WW-1:0] SAT_HI = WW'(2147483647);
    localparam logic signed [WW-1:0] SAT_LO = ~SAT_HI;

    typedef enum logic [1:0] {
        CFG_CENTER_X = 2'd0,
        CFG_CENTER_Y = 2'd1,
        CFG_CENTER_Z = 2'd2,
        CFG_RADIUS   = 2'd3
    } cfg_idx_t;

    typedef logic signed [XW-1:0] coord_t;

    // per particle data that rides along the pipeline
    typedef struct packed {
        coord_t [2:0]          pos;
        coord_t [2:0]          vel;
        logic   [2:0][XW-1:0]  mag;
        logic   [2:0]          neg;
        logic   [XW-1:0]       rs;
        logic                  touch;
    } sb_t;

    // shift right with rounding half away from zero
    function automatic logic signed [WW-1:0] round_shr(input logic signed [WW-1:0] x,
                                                       input int unsigned s);
        logic [WW-1:0] m;
        logic [WW-1:0] q;
        m = x[WW-1] ? (~x + WW'(1)) : x;
        q = (m + (WW'(1) << (s - 1))) >> s;
        return x[WW-1] ? -$signed(q) : $signed(q);
    endfunction

    function automatic coord_t sat32(input logic signed [WW-1:0] x);
        logic signed [WW-1:0] y;
        y = x;
        if (x > SAT_HI)
        begin
            y = SAT_HI;
        end
        if (x < SAT_LO)
        begin
            y = SAT_LO;
        end
        return y[XW-1:0];
    endfunction

endpackage

/* rtl/core/sphere_collision_reflect_core.sv */
// channel | direction | handshake              | payload
// --------+-----------+------------------------+------------------------------------------
// in      | input     | in_valid / in_stall    | pos_x/y/z, vel_x/y/z, particle_radius
// out     | output    | out_valid / out_stall  | new_pos_x/y/z, new_vel_x/y/z, hit
// cfg     | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// one particle request enters per cycle while in_stall is low; coordinates are Q16.16 by default,
// and each request runs through the 32 stage square root and the FRAC_BITS + 1 stage normal divider
// rst_n clears all valid bits and loads center (0,0,0) and radius 1.0
// out_stall freezes the whole pipeline while a result is held at the output;
// with no result at the output everything moves, and in_stall follows out_stall the same cycle
// cfg_ready is always high, writes take effect on the next cycle
module sphere_collision_reflect_core
    import scr_pkg::*;
#(
    parameter int DIM       = 3,
    parameter int FRAC_BITS = 16
)
(
    input  logic          clk,
    input  logic          rst_n,

    input  logic          in_valid,
    output logic          in_stall,
    input  logic [XW-1:0] pos_x,
    input  logic [XW-1:0] pos_y,
    input  logic [XW-1:0] pos_z,
    input  logic [XW-1:0] vel_x,
    input  logic [XW-1:0] vel_y,
    input  logic [XW-1:0] vel_z,
    input  logic [RW-1:0] particle_radius,

    output logic          out_valid,
    input  logic          out_stall,
    output logic [XW-1:0] new_pos_x,
    output logic [XW-1:0] new_pos_y,
    output logic [XW-1:0] new_pos_z,
    output logic [XW-1:0] new_vel_x,
    output logic [XW-1:0] new_vel_y,
    output logic [XW-1:0] new_vel_z,
    output logic          hit,

    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [1:0]    cfg_index,
    input  logic [XW-1:0] cfg_data
);

    localparam int SQL  = 32;                   // square root stages
    localparam int DVL  = FRAC_BITS + 1;        // divider stages
    localparam int NUMW = XW + FRAC_BITS + 1;   // divider numerator
    localparam int NW   = FRAC_BITS + 2;        // signed normal component
    localparam int VNW  = XW + NW;              // v * n
    localparam int RNW  = XW + 1 + NW;          // (R + r) * n
    localparam int AW   = VNW + 2;              // dot accumulator
    localparam int DW   = AW - FRAC_BITS;       // rounded dot
    localparam int DPW  = RNW - FRAC_BITS;      // rounded position offset
    localparam int PCW  = DPW + 1;              // center plus offset
    localparam int TNW  = DW + NW + 1;          // 2 * dot * n
    localparam int DVW  = TNW - FRAC_BITS;      // rounded velocity change
    localparam logic signed [NW-1:0] N_ONE = NW'(2 ** FRAC_BITS);

    // ---------------------------------------------------------------- config
    coord_t        center_reg [3];
    logic [RW-1:0] radius_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg[0] <= '0;
            center_reg[1] <= '0;
            center_reg[2] <= '0;
            radius_reg    <= RW'(65536);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_CENTER_X: center_reg[0] <= cfg_data;
                CFG_CENTER_Y: center_reg[1] <= cfg_data;
                CFG_CENTER_Z: center_reg[2] <= cfg_data;
                CFG_RADIUS:   radius_reg    <= cfg_data[RW-1:0];
                default:      radius_reg    <= radius_reg;
            endcase
        end
    end

    // ---------------------------------------------------------------- flow control
    logic out_vld_reg;
    logic en;

    // the pipeline moves unless a finished result is being held
    assign en       = !out_vld_reg || !out_stall;
    assign in_stall = !en;

    // ---------------------------------------------------------------- stage a: offsets
    coord_t           in_pos [3];
    coord_t           in_vel [3];
    logic signed [XW:0] dlt  [3];
    sb_t              a_sb_next;
    sb_t              a_sb_reg;
    logic             a_vld_reg;

    assign in_pos[0] = pos_x;
    assign in_pos[1] = pos_y;
    assign in_pos[2] = pos_z;
    assign in_vel[0] = vel_x;
    assign in_vel[1] = vel_y;
    assign in_vel[2] = vel_z;

    always_comb
    begin
        a_sb_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            dlt[i] = $signed({in_pos[i][XW-1], in_pos[i]})
                   - $signed({center_reg[i][XW-1], center_reg[i]});
            a_sb_next.pos[i] = in_pos[i];
            a_sb_next.vel[i] = in_vel[i];
            // lanes beyond DIM get a zero offset so they drop out of the sums
            if (i < DIM)
            begin
                a_sb_next.neg[i] = dlt[i][XW];
                a_sb_next.mag[i] = dlt[i][XW] ? XW'(-dlt[i]) : dlt[i][XW-1:0];
            end
        end
        a_sb_next.rs = XW'({1'b0, particle_radius}) + XW'({1'b0, radius_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            a_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_sb_reg <= a_sb_next;
        end
    end

    // ---------------------------------------------------------------- stage b: squares
    logic [2*XW-1:0] b_sq_reg [3];
    logic [2*XW-1:0] b_rs2_reg;
    sb_t             b_sb_reg;
    logic            b_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                b_sq_reg[i] <= a_sb_reg.mag[i] * a_sb_reg.mag[i];
            end
            b_rs2_reg <= a_sb_reg.rs * a_sb_reg.rs;
            b_sb_reg  <= a_sb_reg;
        end
    end

    // ---------------------------------------------------------------- stage c: touch test
    logic [2*XW+1:0] c_sum;
    logic [2*XW-1:0] c_sum_reg;
    sb_t             c_sb_next;
    sb_t             c_sb_reg;
    logic            c_vld_reg;

    always_comb
    begin
        c_sum = (2*XW+2)'(b_sq_reg[0]) + (2*XW+2)'(b_sq_reg[1])
              + (2*XW+2)'(b_sq_reg[2]);
        c_sb_next = b_sb_reg;
        // a particle sitting on the center has no normal and never touches
        c_sb_next.touch = (c_sum <= (2*XW+2)'(b_rs2_reg)) && (c_sum != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            c_vld_reg <= b_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_sum_reg <= c_sum[2*XW-1:0];
            c_sb_reg  <= c_sb_next;
        end
    end

    // ---------------------------------------------------------------- square root
    logic [XW-1:0] dist_root;
    sb_t           sq_sb_reg  [SQL];
    logic          sq_vld_reg [SQL];

    scr_isqrt u_isqrt
    (
        .clk  (clk),
        .en   (en),
        .val  (c_sum_reg),
        .root (dist_root)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < SQL; j++)
            begin
                sq_vld_reg[j] <= 1'b0;
            end
        end
        else if (en)
        begin
            sq_vld_reg[0] <= c_vld_reg;
            for (int j = 1; j < SQL; j++)
            begin
                sq_vld_reg[j] <= sq_vld_reg[j-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_sb_reg[0] <= c_sb_reg;
            for (int j = 1; j < SQL; j++)
            begin
                sq_sb_reg[j] <= sq_sb_reg[j-1];
            end
        end
    end

    // ---------------------------------------------------------------- stage d: numerators
    logic [NUMW-1:0] d_num_reg [3];
    logic [XW-1:0]   d_den_reg;
    sb_t             d_sb_reg;
    logic            d_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            d_vld_reg <= sq_vld_reg[SQL-1];
        end
    end

    // |d| scaled up, plus half the distance for rounding
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                d_num_reg[i] <= NUMW'({sq_sb_reg[SQL-1].mag[i], {FRAC_BITS{1'b0}}})
                              + NUMW'(dist_root >> 1);
            end
            d_den_reg <= dist_root;
            d_sb_reg  <= sq_sb_reg[SQL-1];
        end
    end

    // ---------------------------------------------------------------- normal divide
    logic [FRAC_BITS:0] quo    [3];
    sb_t                dv_sb_reg  [DVL];
    logic               dv_vld_reg [DVL];

    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        scr_div #(
            .FRAC_BITS (FRAC_BITS)
        ) u_div
        (
            .clk (clk),
            .en  (en),
            .num (d_num_reg[i]),
            .den (d_den_reg),
            .quo (quo[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < DVL; j++)
            begin
                dv_vld_reg[j] <= 1'b0;
            end
        end
        else if (en)
        begin
            dv_vld_reg[0] <= d_vld_reg;
            for (int j = 1; j < DVL; j++)
            begin
                dv_vld_reg[j] <= dv_vld_reg[j-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_sb_reg[0] <= d_sb_reg;
            for (int j = 1; j < DVL; j++)
            begin
                dv_sb_reg[j] <= dv_sb_reg[j-1];
            end
        end
    end

    // ---------------------------------------------------------------- stage n: signed normal
    logic signed [NW-1:0] n_reg [3];
    sb_t                  n_sb_reg;
    logic                 n_vld_reg;

    // ---------------------------------------------------------------- stage p: products
    logic signed [VNW-1:0] p_vn_reg  [3];
    logic signed [RNW-1:0] p_rsn_reg [3];
    logic signed [NW-1:0]  p_n_reg   [3];
    sb_t                   p_sb_reg;
    logic                  p_vld_reg;

    // ---------------------------------------------------------------- stage q: dot sum
    logic signed [AW-1:0]  q_acc_reg;
    logic signed [DPW-1:0] q_dp_reg [3];
    logic signed [NW-1:0]  q_n_reg  [3];
    sb_t                   q_sb_reg;
    logic                  q_vld_reg;
    logic signed [WW-1:0]  q_dp_w   [3];

    // ---------------------------------------------------------------- stage r: dot round
    logic signed [DW-1:0]  r_dot_reg;
    logic signed [PCW-1:0] r_pc_reg [3];
    logic signed [NW-1:0]  r_n_reg  [3];
    sb_t                   r_sb_reg;
    logic                  r_vld_reg;
    logic signed [WW-1:0]  r_dot_w;

    // ---------------------------------------------------------------- stage s: 2 dot n
    logic signed [TNW-1:0] s_tdn_reg [3];
    logic signed [PCW-1:0] s_pc_reg  [3];
    sb_t                   s_sb_reg;
    logic                  s_vld_reg;

    // ---------------------------------------------------------------- stage t: round
    logic signed [DVW-1:0] t_dv_reg [3];
    logic signed [PCW-1:0] t_pc_reg [3];
    sb_t                   t_sb_reg;
    logic                  t_vld_reg;
    logic signed [WW-1:0]  t_dv_w   [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            q_dp_w[i] = round_shr(WW'(p_rsn_reg[i]), FRAC_BITS);
            t_dv_w[i] = round_shr(WW'(s_tdn_reg[i]), FRAC_BITS);
        end
        r_dot_w = round_shr(WW'(q_acc_reg), FRAC_BITS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_vld_reg <= 1'b0;
            p_vld_reg <= 1'b0;
            q_vld_reg <= 1'b0;
            r_vld_reg <= 1'b0;
            s_vld_reg <= 1'b0;
            t_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            n_vld_reg <= dv_vld_reg[DVL-1];
            p_vld_reg <= n_vld_reg;
            q_vld_reg <= p_vld_reg;
            r_vld_reg <= q_vld_reg;
            s_vld_reg <= r_vld_reg;
            t_vld_reg <= s_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                n_reg[i] <= dv_sb_reg[DVL-1].neg[i] ? -$signed({1'b0, quo[i]})
                                                    : $signed({1'b0, quo[i]});

                p_vn_reg[i]  <= $signed(n_sb_reg.vel[i]) * n_reg[i];
                p_rsn_reg[i] <= $signed({1'b0, n_sb_reg.rs}) * n_reg[i];
                p_n_reg[i]   <= n_reg[i];

                q_dp_reg[i] <= q_dp_w[i][DPW-1:0];
                q_n_reg[i]  <= p_n_reg[i];

                r_pc_reg[i] <= PCW'($signed(center_reg[i])) + PCW'(q_dp_reg[i]);
                r_n_reg[i]  <= q_n_reg[i];

                s_tdn_reg[i] <= (TNW'(r_dot_reg) * TNW'(r_n_reg[i])) <<< 1;
                s_pc_reg[i]  <= r_pc_reg[i];

                t_dv_reg[i] <= t_dv_w[i][DVW-1:0];
                t_pc_reg[i] <= s_pc_reg[i];
            end
            q_acc_reg <= AW'(p_vn_reg[0]) + AW'(p_vn_reg[1]) + AW'(p_vn_reg[2]);
            r_dot_reg <= r_dot_w[DW-1:0];

            n_sb_reg <= dv_sb_reg[DVL-1];
            p_sb_reg <= n_sb_reg;
            q_sb_reg <= p_sb_reg;
            r_sb_reg <= q_sb_reg;
            s_sb_reg <= r_sb_reg;
            t_sb_reg <= s_sb_reg;
        end
    end

    // ---------------------------------------------------------------- output register
    coord_t out_pos_next [3];
    coord_t out_vel_next [3];
    coord_t out_pos_reg  [3];
    coord_t out_vel_reg  [3];
    logic   hit_reg;

    // touching lanes take the reflected values, everything else passes through
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (t_sb_reg.touch && (i < DIM))
            begin
                out_vel_next[i] = sat32(WW'($signed(t_sb_reg.vel[i])) - WW'(t_dv_reg[i]));
                out_pos_next[i] = sat32(WW'(t_pc_reg[i]));
            end
            else
            begin
                out_vel_next[i] = t_sb_reg.vel[i];
                out_pos_next[i] = t_sb_reg.pos[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= t_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                out_pos_reg[i] <= out_pos_next[i];
                out_vel_reg[i] <= out_vel_next[i];
            end
            hit_reg <= t_sb_reg.touch;
        end
    end

    assign out_valid = out_vld_reg;
    assign new_pos_x = out_pos_reg[0];
    assign new_pos_y = out_pos_reg[1];
    assign new_pos_z = out_pos_reg[2];
    assign new_vel_x = out_vel_reg[0];
    assign new_vel_y = out_vel_reg[1];
    assign new_vel_z = out_vel_reg[2];
    assign hit       = hit_reg;

    // ---------------------------------------------------------------- assertions
    // a touching particle always reaches the divider with a nonzero distance
    a_touch_den: assert property (@(posedge clk) disable iff (!rst_n)
        d_vld_reg && d_sb_reg.touch |-> d_den_reg != '0)
        else $error("zero divisor on a touching particle");

    // normal components of a touching particle stay within one
    a_norm_x: assert property (@(posedge clk) disable iff (!rst_n)
        n_vld_reg && n_sb_reg.touch |-> n_reg[0] <= N_ONE && n_reg[0] >= -N_ONE)
        else $error("normal x out of range");

    a_norm_y: assert property (@(posedge clk) disable iff (!rst_n)
        n_vld_reg && n_sb_reg.touch |-> n_reg[1] <= N_ONE && n_reg[1] >= -N_ONE)
        else $error("normal y out of range");

    a_norm_z: assert property (@(posedge clk) disable iff (!rst_n)
        n_vld_reg && n_sb_reg.touch |-> n_reg[2] <= N_ONE && n_reg[2] >= -N_ONE)
        else $error("normal z out of range");

endmodule

/* rtl/core/scr_isqrt.sv */
module scr_isqrt
    import scr_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] val,
    output logic [31:0] root
);

    localparam int STAGES = 32;
    localparam int REMW   = 34;

    logic [REMW-1:0] rem_reg  [STAGES];
    logic [31:0]     root_reg [STAGES];
    logic [63:0]     val_reg  [STAGES];

    // one root bit per stage, two radicand bits consumed per stage
    for (genvar j = 0; j < STAGES; j++)
    begin : g_stage
        logic [REMW-1:0] rem_in;
        logic [31:0]     root_in;
        logic [63:0]     val_in;
        logic [REMW+1:0] rem_sh;
        logic [REMW+1:0] trial;

        if (j == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign val_in  = val;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[j-1];
            assign root_in = root_reg[j-1];
            assign val_in  = val_reg[j-1];
        end

        assign rem_sh = {rem_in, val_in[63:62]};
        assign trial  = {2'b00, root_in, 2'b01};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rem_sh >= trial)
                begin
                    rem_reg[j]  <= REMW'(rem_sh - trial);
                    root_reg[j] <= {root_in[30:0], 1'b1};
                end
                else
                begin
                    rem_reg[j]  <= rem_sh[REMW-1:0];
                    root_reg[j] <= {root_in[30:0], 1'b0};
                end
                val_reg[j] <= {val_in[61:0], 2'b00};
            end
        end
    end

    assign root = root_reg[STAGES-1];

endmodule

/* rtl/core/scr_div.sv */
module scr_div
    import scr_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                      clk,
    input  logic                      en,
    input  logic [XW+FRAC_BITS:0]     num,
    input  logic [XW-1:0]             den,
    output logic [FRAC_BITS:0]        quo
);

    localparam int NUMW   = XW + FRAC_BITS + 1;
    localparam int STAGES = FRAC_BITS + 1;

    logic [NUMW-1:0]    rem_reg [STAGES];
    logic [XW-1:0]      den_reg [STAGES];
    logic [FRAC_BITS:0] quo_reg [STAGES];

    // restoring division, one quotient bit per stage from the top
    for (genvar j = 0; j < STAGES; j++)
    begin : g_stage
        localparam int K = FRAC_BITS - j;
        logic [NUMW-1:0]    rem_in;
        logic [XW-1:0]      den_in;
        logic [FRAC_BITS:0] quo_in;
        logic [NUMW-1:0]    cmp;

        if (j == 0)
        begin : g_first
            assign rem_in = num;
            assign den_in = den;
            assign quo_in = '0;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[j-1];
            assign den_in = den_reg[j-1];
            assign quo_in = quo_reg[j-1];
        end

        assign cmp = NUMW'(den_in) << K;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rem_in >= cmp)
                begin
                    rem_reg[j] <= rem_in - cmp;
                    quo_reg[j] <= {quo_in[FRAC_BITS-1:0], 1'b1};
                end
                else
                begin
                    rem_reg[j] <= rem_in;
                    quo_reg[j] <= {quo_in[FRAC_BITS-1:0], 1'b0};
                end
                den_reg[j] <= den_in;
            end
        end
    end

    assign quo = quo_reg[STAGES-1];

endmodule

/* test/tb_sphere_collision_reflect_core.sv */
`timescale 1ns / 1ps

// stream particles into the collision stage and compare every result against a
// hand-typed expectation or a local fixed point model of the sphere reflection
module tb_sphere_collision_reflect_core;
    import scr_pkg::*;

    localparam int FRAC       = 16;
    localparam int LATENCY    = FRAC + 44;
    localparam int IDLE_LIMIT = 20000;  // cycles without any accepted request
    localparam int HOLD_LEN   = 300;    // long receiver hold-off

    typedef struct {
        logic [XW-1:0] p[3];
        logic [XW-1:0] v[3];
        logic [RW-1:0] r;
    } particle_t;

    typedef struct {
        logic [XW-1:0] p[3];
        logic [XW-1:0] v[3];
        logic          hit;
    } bounce_t;

    typedef struct {
        particle_t part;
        bit        typed;   // expected result given by hand
        bounce_t   res;
    } row_t;

    logic          clk;
    logic          rst_n;
    logic          in_valid;
    logic          in_stall;
    logic [XW-1:0] pos_x, pos_y, pos_z, vel_x, vel_y, vel_z;
    logic [RW-1:0] particle_radius;
    logic          out_valid;
    logic          out_stall;
    logic [XW-1:0] new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z;
    logic          hit;
    logic          cfg_valid;
    logic          cfg_ready;
    logic [1:0]    cfg_index;
    logic [XW-1:0] cfg_data;

    // local copy of the obstacle registers
    longint        obst_center[3];
    logic [63:0]   obst_radius;

    bounce_t       bounce_q[$];
    int            n_sent;
    int            n_seen;
    int            n_hits;
    int            n_bad;
    int            idle_pct;
    int            stall_pct;
    bit            hold_req;
    bit            hold_done;
    int            hold_left;
    int            quiet;

    sphere_collision_reflect_core i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .pos_x           (pos_x),
        .pos_y           (pos_y),
        .pos_z           (pos_z),
        .vel_x           (vel_x),
        .vel_y           (vel_y),
        .vel_z           (vel_z),
        .particle_radius (particle_radius),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .new_pos_x       (new_pos_x),
        .new_pos_y       (new_pos_y),
        .new_pos_z       (new_pos_z),
        .new_vel_x       (new_vel_x),
        .new_vel_y       (new_vel_y),
        .new_vel_z       (new_vel_z),
        .hit             (hit),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    // rounding shift by the fraction width, half away from zero
    function automatic longint frac_round(longint x);
        logic [63:0] mg;
        mg = (x < 0) ? -x : x;
        mg = (mg + (64'd1 << (FRAC - 1))) >> FRAC;
        return (x < 0) ? -longint'(mg) : longint'(mg);
    endfunction

    function automatic logic [XW-1:0] clamp32(longint x);
        if (x > 64'sd2147483647)
        begin
            return 32'h7fff_ffff;
        end
        if (x < -64'sd2147483648)
        begin
            return 32'h8000_0000;
        end
        return x[XW-1:0];
    endfunction

    // floor square root, one result bit per step
    function automatic logic [63:0] floor_sqrt(logic [63:0] val);
        logic [63:0] root;
        logic [63:0] trial;
        root = 0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= val)
            begin
                root = trial;
            end
        end
        return root;
    endfunction

    // reflect one particle off the configured sphere
    function automatic bounce_t reflect(particle_t pt);
        bounce_t     res;
        longint      d[3];
        longint      nrm[3];
        longint      acc;
        longint      dot;
        logic [63:0] mg[3];
        logic [127:0] sum;
        logic [63:0] rs;
        logic [63:0] dist_root;
        logic [63:0] q;
        res.p   = pt.p;
        res.v   = pt.v;
        res.hit = 1'b0;
        rs  = 64'(pt.r) + obst_radius;
        sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            d[i]  = longint'($signed(pt.p[i])) - obst_center[i];
            mg[i] = (d[i] < 0) ? -d[i] : d[i];
            sum   = sum + 128'(mg[i]) * 128'(mg[i]);
        end
        // rs squared stays below 2^64, so a wide sum never counts as touching
        if (sum == 0 || sum > 128'(rs) * 128'(rs))
        begin
            return res;
        end
        dist_root = floor_sqrt(sum[63:0]);
        acc  = 0;
        for (int i = 0; i < 3; i++)
        begin
            q      = ((mg[i] << FRAC) + dist_root / 2) / dist_root;
            nrm[i] = (d[i] < 0) ? -longint'(q) : longint'(q);
            acc    = acc + longint'($signed(pt.v[i])) * nrm[i];
        end
        dot = frac_round(acc);
        for (int i = 0; i < 3; i++)
        begin
            res.v[i] = clamp32(longint'($signed(pt.v[i])) - frac_round(2 * dot * nrm[i]));
            res.p[i] = clamp32(obst_center[i] + frac_round(longint'(rs) * nrm[i]));
        end
        res.hit = 1'b1;
        return res;
    endfunction

    function automatic void check_field(string name, logic [XW-1:0] exp_v, logic [XW-1:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            n_bad++;
        end
    endfunction

    // offer one particle, idling first at the current rate
    task automatic send_particle(particle_t pt, bit typed, bounce_t res);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid        <= 1'b1;
        pos_x           <= pt.p[0];
        pos_y           <= pt.p[1];
        pos_z           <= pt.p[2];
        vel_x           <= pt.v[0];
        vel_y           <= pt.v[1];
        vel_z           <= pt.v[2];
        particle_radius <= pt.r;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        bounce_q.push_back(typed ? res : reflect(pt));
        n_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (bounce_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // register writes only once the pipeline is empty
    task automatic write_reg(cfg_idx_t idx, logic [XW-1:0] val);
        drain();
        repeat (LATENCY + 20) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        if (idx == CFG_RADIUS)
        begin
            obst_radius = 64'(val[RW-1:0]);
        end
        else
        begin
            obst_center[idx] = longint'($signed(val));
        end
    endtask

    function automatic logic [XW-1:0] rand_word();
        return $urandom();
    endfunction

    // mostly particles near the sphere surface, plus center hits and noise
    function automatic particle_t rand_particle();
        particle_t pt;
        longint    lim;
        int        kind;
        kind = $urandom_range(0, 99);
        for (int i = 0; i < 3; i++)
        begin
            pt.v[i] = (kind < 50) ? XW'($signed($urandom_range(0, 1 << 20)) - (1 << 19))
                                  : rand_word();
        end
        pt.r = ($urandom_range(0, 3) == 0) ? RW'($urandom()) : RW'($urandom_range(0, 1 << 18));
        if (kind < 20)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pt.p[i] = rand_word();
            end
        end
        else if (kind < 28)
        begin
            // exactly on the obstacle center
            for (int i = 0; i < 3; i++)
            begin
                pt.p[i] = obst_center[i][XW-1:0];
            end
        end
        else
        begin
            lim = longint'(pt.r) + longint'(obst_radius);
            if (lim > 64'sd1073741823)
            begin
                lim = 64'sd1073741823;
            end
            if (lim < 1)
            begin
                lim = 1;
            end
            for (int i = 0; i < 3; i++)
            begin
                pt.p[i] = XW'(obst_center[i] + longint'($urandom_range(0, 32'(2 * lim))) - lim);
            end
        end
        return pt;
    endfunction

    // receiver: random stalls plus one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_req && !hold_done)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_LEN;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (bounce_q.size() == 0)
            begin
                $error("result with nothing expected");
                n_bad++;
            end
            else
            begin
                bounce_t e;
                e = bounce_q.pop_front();
                check_field("new_pos_x", e.p[0], new_pos_x);
                check_field("new_pos_y", e.p[1], new_pos_y);
                check_field("new_pos_z", e.p[2], new_pos_z);
                check_field("new_vel_x", e.v[0], new_vel_x);
                check_field("new_vel_y", e.v[1], new_vel_y);
                check_field("new_vel_z", e.v[2], new_vel_z);
                check_field("hit", 32'(e.hit), 32'(hit));
                n_hits += e.hit;
            end
            n_seen++;
        end
    end

    // watchdog on cycles with no accepted request on the in or the out channel
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
        begin
            quiet <= 0;
        end
        else
        begin
            quiet <= quiet + 1;
            if (quiet >= IDLE_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial
    begin
        row_t      dir_rows[$];
        row_t      row;
        particle_t pt;
        bounce_t   none;
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        pos_x           = '0;
        pos_y           = '0;
        pos_z           = '0;
        vel_x           = '0;
        vel_y           = '0;
        vel_z           = '0;
        particle_radius = '0;
        out_stall       = 1'b0;
        cfg_valid       = 1'b0;
        cfg_index       = CFG_CENTER_X;
        cfg_data        = '0;
        hold_req        = 1'b0;
        hold_done       = 1'b0;
        hold_left       = 0;
        quiet           = 0;
        n_sent          = 0;
        n_seen          = 0;
        n_hits          = 0;
        n_bad           = 0;
        idle_pct        = 0;
        stall_pct       = 0;
        obst_center     = '{0, 0, 0};
        obst_radius     = 64'd65536;
        none.hit        = 1'b0;
        none.p          = '{0, 0, 0};
        none.v          = '{0, 0, 0};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, reset registers: center at origin, radius 1.0
        // particle on the obstacle center passes unchanged
        row.typed = 1'b1;
        row.part.p = '{0, 0, 0};
        row.part.v = '{32'h0001_0000, 32'hffff_0000, 32'h0000_8000};
        row.part.r = RW'(65536);
        row.res.p = row.part.p;
        row.res.v = row.part.v;
        row.res.hit = 1'b0;
        dir_rows.push_back(row);
        // head-on at (2.0,0,0): velocity flips, position pinned to distance 2.0
        row.part.p = '{32'h0002_0000, 0, 0};
        row.part.v = '{32'hffff_0000, 0, 0};
        row.res.p = '{32'h0002_0000, 0, 0};
        row.res.v = '{32'h0001_0000, 0, 0};
        row.res.hit = 1'b1;
        dir_rows.push_back(row);
        // all-extreme fields, far outside: unchanged
        row.part.p = '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff};
        row.part.v = '{32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff};
        row.part.r = '1;
        row.res.p = row.part.p;
        row.res.v = row.part.v;
        row.res.hit = 1'b0;
        dir_rows.push_back(row);
        row.part.p = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
        row.part.r = '0;
        row.res.p = row.part.p;
        dir_rows.push_back(row);
        // remaining rows go through the model
        row.typed = 1'b0;
        row.part.r = '0;
        row.part.p = '{0, 32'h0001_0000, 0};   // just touching with r of zero
        row.part.v = '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff};
        dir_rows.push_back(row);
        row.part.p = '{0, 0, 32'h0001_0001};   // one lsb outside
        dir_rows.push_back(row);
        row.part.p = '{32'hffff_8000, 32'h0000_8000, 32'hffff_8000};
        row.part.r = '1;                       // huge particle radius
        dir_rows.push_back(row);
        row.part.p = '{1, 0, 0};               // tiniest offset from center
        row.part.v = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
        dir_rows.push_back(row);
        row.part.p = '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff};
        dir_rows.push_back(row);
        foreach (dir_rows[k])
        begin
            send_particle(dir_rows[k].part, dir_rows[k].typed, dir_rows[k].res);
        end
        drain();

        // directed extremes of the registers
        write_reg(CFG_CENTER_X, 32'h7fff_ffff);
        write_reg(CFG_CENTER_Y, 32'h8000_0000);
        write_reg(CFG_CENTER_Z, 32'h7fff_ffff);
        write_reg(CFG_RADIUS, 32'h7fff_ffff);
        for (int k = 0; k < 8; k++)
        begin
            send_particle(rand_particle(), 1'b0, none);
        end

        // four random phases, each with its own obstacle and idling mix
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                    write_reg(CFG_RADIUS, 32'd0);
                    write_reg(CFG_CENTER_X, 32'h8000_0000);
                end
                1:
                begin
                    idle_pct  = 55;
                    stall_pct = 0;
                    write_reg(CFG_CENTER_X, 32'h0000_0000);
                    write_reg(CFG_CENTER_Y, 32'h0000_0000);
                    write_reg(CFG_CENTER_Z, 32'h0000_0000);
                    write_reg(CFG_RADIUS, 32'h0001_0000);
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 55;
                    write_reg(CFG_CENTER_X, rand_word());
                    write_reg(CFG_CENTER_Y, rand_word());
                    write_reg(CFG_RADIUS, 32'($urandom_range(1, 1 << 24)));
                end
                default:
                begin
                    idle_pct  = 36;
                    stall_pct = 36;
                    write_reg(CFG_CENTER_Z, 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21)));
                    write_reg(CFG_RADIUS, 32'($urandom_range(1 << 14, 1 << 20)));
                end
            endcase
            for (int k = 0; k < 200; k++)
            begin
                // long receiver hold-off while items keep coming
                if (ph == 0 && k == 40)
                begin
                    hold_req = 1'b1;
                end
                // sender waits for the pipeline to empty once
                if (ph == 1 && k == 100)
                begin
                    drain();
                end
                send_particle(rand_particle(), 1'b0, none);
            end
        end

        drain();
        repeat (LATENCY + 20) @(posedge clk);
        $display("tb: %0d particles sent, %0d results checked, %0d reflected", n_sent, n_seen,
                 n_hits);
        $display("tb: covered register extremes, center hits, saturation and four idle mixes");
        if (n_bad == 0 && bounce_q.size() == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
